[src/rgb_to_hsv_pixel_defines.svh]
// assertion macros for the hsv block
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH
`ifndef SYNTHESIS
`define HSV_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("hsv assertion failed");
`define HSV_ASSERT_IMP(label, ante, cons) \
	`HSV_ASSERT(label, (ante) |-> (cons))
`else
`define HSV_ASSERT(label, prop)
`define HSV_ASSERT_IMP(label, ante, cons)
`endif
`endif

[src/hsv_pkg.sv]
`default_nettype none
package hsv_pkg;
	localparam int ChW      = 8;
	localparam int QW       = 8;
	localparam int HueNumW  = 21;
	localparam int HueDenW  = 13;
	localparam int SatNumW  = 16;
	localparam int SatDenW  = 8;

	typedef struct packed {
		logic [ChW-1:0] red;
		logic [ChW-1:0] green;
		logic [ChW-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [ChW-1:0] hue;
		logic [ChW-1:0] saturation;
		logic [ChW-1:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [HueNumW-1:0] hnum;
		logic [HueDenW-1:0] hden;
		logic [SatNumW-1:0] snum;
		logic [SatDenW-1:0] sden;
		logic [ChW-1:0]     bright;
	} front_t;
endpackage
`default_nettype wire

[src/hsv_front.sv]
`default_nettype none
module hsv_front (
	input  wire                  clk,
	input  hsv_pkg::pixel_t      pixel,
	output hsv_pkg::front_t      front_s1
);
	logic [7:0] r, g, b, mx, mn, c;
	logic signed [18:0] c_s, d_s, base_s, num_s;
	logic [16:0] num_u;
	hsv_pkg::front_t nxt;

	always_comb begin
		r = pixel.red;
		g = pixel.green;
		b = pixel.blue;
		mx = (r > g) ? r : g;
		if (b > mx) mx = b;
		mn = (r < g) ? r : g;
		if (b < mn) mn = b;
		c = mx - mn;
		c_s = signed'({11'b0, c});
		// ties: blue over green over red
		priority if (mx == b) begin
			base_s = 19'sd240 * c_s;
			d_s = signed'({11'b0, r}) - signed'({11'b0, g});
		end else if (mx == g) begin
			base_s = 19'sd120 * c_s;
			d_s = signed'({11'b0, b}) - signed'({11'b0, r});
		end else begin
			base_s = '0;
			d_s = signed'({11'b0, g}) - signed'({11'b0, b});
		end
		num_s = base_s + 19'sd60 * d_s;
		if (num_s < 0) num_s = num_s + 19'sd360 * c_s;
		num_u = num_s[16:0];
		// 255/360 reduces to 17/24
		if (c == 8'd0) begin
			nxt.hnum = '0;
			nxt.hden = 13'd24;
		end else begin
			nxt.hnum = 21'(num_u) * 21'd17;
			nxt.hden = 13'(c) * 13'd24;
		end
		nxt.snum = 16'(c) * 16'd255;
		nxt.sden = (mx == 8'd0) ? 8'd1 : mx;
		nxt.bright = mx;
	end

	always_ff @(posedge clk) begin
		front_s1 <= nxt;
	end
endmodule
`default_nettype wire

[src/hsv_div_cell.sv]
`default_nettype none
module hsv_div_cell #(
	parameter int NUM_W = 21,
	parameter int DEN_W = 13,
	parameter int SHIFT = 7,
	parameter int Q_W   = 8
) (
	input  wire              clk,
	input  wire [NUM_W-1:0]  rem_in,
	input  wire [DEN_W-1:0]  den_in,
	input  wire [Q_W-1:0]    q_in,
	output logic [NUM_W-1:0] rem_q,
	output logic [DEN_W-1:0] den_q,
	output logic [Q_W-1:0]   q_q
);
	logic [NUM_W:0] trial;
	logic           take;

	always_comb begin
		trial = {{(NUM_W+1-DEN_W){1'b0}}, den_in} << SHIFT;
		take = {1'b0, rem_in} >= trial;
	end

	// one restoring step per cell
	always_ff @(posedge clk) begin
		rem_q <= take ? NUM_W'({1'b0, rem_in} - trial) : rem_in;
		den_q <= den_in;
		q_q <= {q_in[Q_W-2:0], take};
	end
endmodule
`default_nettype wire

[src/rgb_to_hsv_pixel.sv]
// rgb_to_hsv_pixel: one rgb pixel with 8-bit channels in, one hue/saturation/brightness word out.
// input: drive pixel and pulse start; a word is taken at each edge with start high
// and busy low. busy is always low, so a pixel may enter every clock.
// output: done is high for one cycle with the result word; the receiver must take
// it then, as nothing holds results back.
// throughput: one pixel per clock.
// stage one finds max, min, chroma and the hue sector numerator; then two rows
// of 8 divider cells (hue and saturation) each resolve one quotient bit per cycle.
// reset clears only the valid pipe; words in flight at reset are dropped.
// brightness is the channel maximum, saturation is floor(255*chroma/max),
// hue is floor(degrees*255/360) with ties won by blue, then green.
`default_nettype none
`include "rgb_to_hsv_pixel_defines.svh"
module rgb_to_hsv_pixel (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  hsv_pkg::pixel_t  pixel,
	output logic             done,
	output hsv_pkg::hsv_t    result
);
	localparam int Q = hsv_pkg::QW;

	hsv_pkg::front_t front_s1;
	logic [Q:0] vld_q;
	logic [hsv_pkg::ChW-1:0] bright_q [Q];

	logic [hsv_pkg::HueNumW-1:0] hrem [Q+1];
	logic [hsv_pkg::HueDenW-1:0] hden [Q+1];
	logic [Q-1:0]                hq   [Q+1];
	logic [hsv_pkg::SatNumW-1:0] srem [Q+1];
	logic [hsv_pkg::SatDenW-1:0] sden [Q+1];
	logic [Q-1:0]                sq   [Q+1];

	assign busy = 1'b0;

	hsv_front u_front (
		.clk      (clk),
		.pixel    (pixel),
		.front_s1 (front_s1)
	);

	always_comb begin
		hrem[0] = front_s1.hnum;
		hden[0] = front_s1.hden;
		hq[0]   = '0;
		srem[0] = front_s1.snum;
		sden[0] = front_s1.sden;
		sq[0]   = '0;
	end

	for (genvar i = 0; i < Q; i++) begin : g_cell
		hsv_div_cell #(
			.NUM_W (hsv_pkg::HueNumW),
			.DEN_W (hsv_pkg::HueDenW),
			.SHIFT (Q-1-i),
			.Q_W   (Q)
		) u_hue (
			.clk (clk), .rem_in (hrem[i]), .den_in (hden[i]), .q_in (hq[i]),
			.rem_q (hrem[i+1]), .den_q (hden[i+1]), .q_q (hq[i+1])
		);
		hsv_div_cell #(
			.NUM_W (hsv_pkg::SatNumW),
			.DEN_W (hsv_pkg::SatDenW),
			.SHIFT (Q-1-i),
			.Q_W   (Q)
		) u_sat (
			.clk (clk), .rem_in (srem[i]), .den_in (sden[i]), .q_in (sq[i]),
			.rem_q (srem[i+1]), .den_q (sden[i+1]), .q_q (sq[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[Q-1:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		bright_q[0] <= front_s1.bright;
		for (int k = 1; k < Q; k++) bright_q[k] <= bright_q[k-1];
	end

	always_comb begin
		done = vld_q[Q];
		result.hue = hq[Q];
		result.saturation = sq[Q];
		result.brightness = bright_q[Q-1];
	end

	`HSV_ASSERT(a_never_busy, !busy)
	`HSV_ASSERT_IMP(a_black_no_sat, done && result.brightness == '0, result.saturation == '0)
	`HSV_ASSERT_IMP(a_grey_no_hue, done && result.saturation == '0, result.hue == '0)
endmodule
`default_nettype wire
